// ----- design/srls_pkg.sv -----
// Package for the spectrum to RGB level smoother: payload types, register
// indexes and fixed-point constants. No dependencies.
package srls_pkg;

  typedef struct packed {
    logic        operation;
    logic [7:0]  bin_index;
    logic [15:0] bin_amplitude;
    logic [16:0] green_weight;
    logic [15:0] loudness_gain;
    logic        last_of_frame;
    logic [19:0] frame_time_us;
  } srls_in_t;

  typedef struct packed {
    logic [11:0] red_level;
    logic [11:0] green_level;
    logic [11:0] blue_level;
  } srls_out_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_RED_SCALE   = 3'd0;
  localparam logic [2:0] REG_BLUE_SCALE  = 3'd1;
  localparam logic [2:0] REG_OVERALL     = 3'd2;
  localparam logic [2:0] REG_LIMIT       = 3'd3;
  localparam logic [2:0] REG_PIVOT       = 3'd4;
  localparam logic [2:0] REG_RISE        = 3'd5;
  localparam logic [2:0] REG_FALL        = 3'd6;

  localparam logic [47:0] SUM_MAX = {48{1'b1}};
  localparam logic [16:0] W_ONE   = 17'h10000;

endpackage

// ----- design/srls_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the frame-end math.
// Depends on srls_pkg only through the shared house style.
module srls_divider import srls_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], quo_q[NW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ----- design/spectrum_to_rgb_level_smoother_unit.sv -----
// Top level of the spectrum to RGB level smoother: bin table memory,
// power accumulation and the frame-end sequencer. Uses srls_pkg, srls_divider.
//
// A table write is done when its word is accepted. For a sample that does not
// end a frame, the word is accepted while the bin's weight and gain are read
// from one synchronous table memory, then a wait state, a gain multiply, a
// squaring and a weight multiply are each registered before the sums are updated.
// A sample that ends a frame then runs a frame-end sequence: three square roots
// of one result bit per cycle, each with operand load and store, the scale
// multiplies, then two size divisions and three average divisions on a shared
// radix-2 divider; the divisions are skipped when the frame time is zero. The
// result word waits in an output register while the next word may already be
// accepted; a later result waits in the sequencer until the earlier one has
// been taken.
module spectrum_to_rgb_level_smoother_unit import srls_pkg::*; #(
  parameter int USE_BINS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  srls_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output srls_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // States.
  localparam logic [4:0] S_IDLE = 5'd0,  S_RD = 5'd1,  S_M1 = 5'd2,  S_M2 = 5'd3,
                         S_M3 = 5'd4,    S_ACC = 5'd5, S_SQ = 5'd6,  S_SQN = 5'd7,
                         S_SC = 5'd8,    S_OV = 5'd9,  S_DV1 = 5'd10, S_DV1W = 5'd11,
                         S_DV2 = 5'd12,  S_DV2W = 5'd13, S_AV = 5'd14, S_AVW = 5'd15,
                         S_OUT = 5'd16,  S_SQL = 5'd17;

  // Configuration registers.
  logic [15:0] red_scale_q, blue_scale_q, overall_q;
  logic [11:0] limit_q;
  logic [8:0]  pivot_q;
  logic [23:0] rise_q, fall_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_scale_q  <= 16'd9860;
      blue_scale_q <= 16'd6592;
      overall_q    <= 16'd12000;
      limit_q      <= 12'd4095;
      pivot_q      <= 9'd64;
      rise_q       <= 24'd166950;
      fall_q       <= 24'd500850;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_RED_SCALE:  red_scale_q  <= pwdata[15:0];
        REG_BLUE_SCALE: blue_scale_q <= pwdata[15:0];
        REG_OVERALL:    overall_q    <= pwdata[15:0];
        REG_LIMIT:      limit_q      <= pwdata[11:0];
        REG_PIVOT:      pivot_q      <= pwdata[8:0];
        REG_RISE:       rise_q       <= pwdata[23:0];
        REG_FALL:       fall_q       <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RED_SCALE:  prdata = {16'd0, red_scale_q};
      REG_BLUE_SCALE: prdata = {16'd0, blue_scale_q};
      REG_OVERALL:    prdata = {16'd0, overall_q};
      REG_LIMIT:      prdata = {20'd0, limit_q};
      REG_PIVOT:      prdata = {23'd0, pivot_q};
      REG_RISE:       prdata = {8'd0, rise_q};
      REG_FALL:       prdata = {8'd0, fall_q};
      default:        prdata = '0;
    endcase
  end

  // Bin table: weight and gain in one word.
  logic [32:0] tab_mem [256];
  logic [32:0] tab_rd_q;

  logic [4:0]  state_q;
  srls_in_t    item_q;
  logic [19:0] a_q;
  logic [47:0] pow_q;
  logic [47:0] grn_q;
  logic [47:0] sum_q [3];
  logic [23:0] avg_q [3];
  logic [1:0]  ch_q;
  logic [47:0] sq_v_q;
  logic [47:0] sq_r_q;
  logic [4:0]  sq_cnt_q;
  logic [27:0] mag_q [3];
  logic [47:0] tgt_q [3];
  logic [47:0] up_q, dn_q;
  logic        out_valid_q;
  srls_out_t   out_q;

  logic        accept;
  logic        out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // The read is taken with the accepted word and held for the whole sample.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.operation == OP_WRITE)
      tab_mem[in_data_i.bin_index] <= {in_data_i.green_weight, in_data_i.loudness_gain};
    if (accept) tab_rd_q <= tab_mem[in_data_i.bin_index];
  end

  // Shared divider.
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_quo;
  logic [39:0] dv_den;

  srls_divider #(.NW(64), .DW(40)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // Combinational helpers.
  logic [16:0] w_sat;
  logic [64:0] grn_full;
  logic [47:0] red_add;
  logic [48:0] s_g, s_o;
  logic        to_red, in_range;
  logic [47:0] sq_bit, sq_trial;
  logic [35:0] size_sel;
  logic [23:0] avg_cur;
  logic [47:0] tgt_cur;
  logic [47:0] up_f, dn_f;

  assign w_sat    = (tab_rd_q[32:16] > W_ONE) ? W_ONE : tab_rd_q[32:16];
  assign grn_full = 65'(pow_q) * 65'(w_sat);
  assign in_range = 32'(item_q.bin_index) < 32'(USE_BINS);
  assign to_red   = {1'b0, item_q.bin_index} < pivot_q;
  assign red_add  = pow_q - grn_q;
  assign s_g      = {1'b0, sum_q[1]} + {1'b0, grn_q};
  assign s_o      = {1'b0, to_red ? sum_q[0] : sum_q[2]} + {1'b0, red_add};
  assign sq_bit   = 48'd1 << {sq_cnt_q, 1'b0};
  assign sq_trial = sq_r_q + sq_bit;
  assign tgt_cur  = tgt_q[ch_q];
  assign avg_cur  = avg_q[ch_q];
  assign up_f     = (up_q <= 48'd4096) ? 48'd4096 : up_q;
  assign dn_f     = (dn_q <= 48'd4096) ? 48'd4096 : dn_q;
  assign size_sel = (tgt_cur > 48'(avg_cur)) ? up_f[35:0] : dn_f[35:0];

  logic [23:0] lim24;
  assign lim24 = {limit_q, 12'd0};

  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    case (state_q)
      S_DV1: begin
        dv_start = 1'b1;
        dv_num   = {28'd0, rise_q, 12'd0};
        dv_den   = {20'd0, item_q.frame_time_us};
      end
      S_DV2: begin
        dv_start = 1'b1;
        dv_num   = {28'd0, fall_q, 12'd0};
        dv_den   = {20'd0, item_q.frame_time_us};
      end
      S_AV: begin
        dv_start = 1'b1;
        dv_num   = 64'(60'(size_sel - 36'd4096) * 60'(avg_cur)) + {4'd0, tgt_cur, 12'd0};
        dv_den   = {4'd0, size_sel};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      avg_q[0]    <= '0;
      avg_q[1]    <= '0;
      avg_q[2]    <= '0;
      ch_q        <= '0;
      sq_cnt_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (accept) state_q <= (in_data_i.operation == OP_WRITE) ? S_IDLE : S_RD;
        S_RD:   state_q <= S_M1;
        S_M1:   state_q <= S_M2;
        S_M2:   state_q <= S_M3;
        S_M3:   state_q <= S_ACC;
        S_ACC: begin
          if (in_range) begin
            sum_q[1] <= s_g[48] ? SUM_MAX : s_g[47:0];
            if (to_red) sum_q[0] <= s_o[48] ? SUM_MAX : s_o[47:0];
            else        sum_q[2] <= s_o[48] ? SUM_MAX : s_o[47:0];
          end
          ch_q     <= '0;
          state_q  <= item_q.last_of_frame ? S_SQL : S_IDLE;
        end
        S_SQL: begin
          sq_cnt_q <= 5'd23;
          state_q  <= S_SQ;
        end
        // One root bit per cycle; rows are the three sums.
        S_SQ: begin
          if (sq_cnt_q == 5'd0) state_q <= S_SQN;
          sq_cnt_q <= sq_cnt_q - 1'b1;
        end
        S_SQN: begin
          if (ch_q == 2'd2) begin
            ch_q    <= '0;
            sum_q[0] <= '0;
            sum_q[1] <= '0;
            sum_q[2] <= '0;
            state_q <= S_SC;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_SQL;
          end
        end
        S_SC: state_q <= S_OV;
        S_OV: state_q <= (item_q.frame_time_us == 20'd0) ? S_OUT : S_DV1;
        S_DV1:  state_q <= S_DV1W;
        S_DV1W: if (dv_done) state_q <= S_DV2;
        S_DV2:  state_q <= S_DV2W;
        S_DV2W: if (dv_done) begin
          ch_q    <= '0;
          state_q <= S_AV;
        end
        S_AV:  state_q <= S_AVW;
        S_AVW: if (dv_done) begin
          avg_q[ch_q] <= (dv_quo > 64'(lim24)) ? lim24 : dv_quo[23:0];
          if (ch_q == 2'd2) state_q <= S_OUT;
          else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_AV;
          end
        end
        S_OUT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == S_M1) a_q <= 20'((32'(item_q.bin_amplitude) * 32'(tab_rd_q[15:0])) >> 12);
    if (state_q == S_M2) pow_q <= 48'(a_q) * 48'(a_q);
    if (state_q == S_M3) grn_q <= grn_full[63:16];
    if (state_q == S_SQL) begin
      sq_v_q <= sum_q[ch_q];
      sq_r_q <= '0;
    end
    if (state_q == S_SQ) begin
      if (sq_v_q >= sq_trial) begin
        sq_v_q <= sq_v_q - sq_trial;
        sq_r_q <= (sq_r_q >> 1) + sq_bit;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
    end
    if (state_q == S_SQN) mag_q[ch_q] <= {4'd0, sq_r_q[23:0]};
    if (state_q == S_SC) begin
      mag_q[0] <= 28'((40'(mag_q[0]) * 40'(red_scale_q)) >> 12);
      mag_q[2] <= 28'((40'(mag_q[2]) * 40'(blue_scale_q)) >> 12);
    end
    if (state_q == S_OV) begin
      for (int c = 0; c < 3; c++) begin
        tgt_q[c] <= 48'((44'(mag_q[c]) * 44'(overall_q)) >> 4);
      end
    end
    if (state_q == S_DV1W && dv_done) up_q <= dv_quo[47:0];
    if (state_q == S_DV2W && dv_done) dn_q <= dv_quo[47:0];
    if ((state_q == S_OUT) && out_free) begin
      out_q.red_level   <= avg_q[0][23:12];
      out_q.green_level <= avg_q[1][23:12];
      out_q.blue_level  <= avg_q[2][23:12];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q) else $error("result dropped");
  a_sums_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC) |-> (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0))
    else $error("sums not cleared");
endmodule

// ----- tb/spectrum_to_rgb_level_smoother_unit_tb.sv -----
// Testbench for the spectrum to RGB level smoother: directed and random bin
// words checked against a built-in fixed-point predictor of the level outputs.
// Depends on srls_pkg and spectrum_to_rgb_level_smoother_unit only.
`timescale 1ns / 100ps

module spectrum_to_rgb_level_smoother_unit_tb;
  import srls_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam int LONG_HOLD    = 1500;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  srls_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  srls_out_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spectrum_to_rgb_level_smoother_unit uut (.*);

  // Predictor state.
  bit [15:0] red_scale_q, blue_scale_q, overall_q;
  bit [11:0] limit_q;
  bit [8:0]  pivot_q;
  bit [23:0] rise_base_q, fall_base_q;
  bit [16:0] weight_tab[256];
  bit [15:0] gain_tab[256];
  bit        bin_loaded[256];
  bit [63:0] red_sum, green_sum, blue_sum;
  bit [63:0] level_q12[3];

  srls_out_t expected_levels[$];
  int        mismatch_count;
  int        idle_cycles;
  bit        rx_long_hold;
  bit        tx_no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return (s > {16'd0, SUM_MAX}) ? {16'd0, SUM_MAX} : s;
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] trial;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic bit [63:0] step_size(bit [63:0] base, bit [63:0] dt);
    bit [63:0] s;
    s = (base << 12) / dt;
    return (s <= 64'd4096) ? 64'd4096 : s;
  endfunction

  function automatic void settle_level(int c, bit [63:0] target, bit [63:0] up,
                                       bit [63:0] dn);
    bit [63:0] sz;
    bit [63:0] avg;
    sz  = (target > level_q12[c]) ? up : dn;
    avg = ((sz - 64'd4096) * level_q12[c] + target * 64'd4096) / sz;
    if (avg > ({52'd0, limit_q} << 12)) avg = {52'd0, limit_q} << 12;
    level_q12[c] = avg;
  endfunction

  // Applies one accepted word to the predictor and queues any level result.
  function automatic void predict_levels(srls_in_t w);
    bit [63:0] amp, gsh, pw, wt, mr, mg, mb, up, dn;
    srls_out_t r;
    if (w.operation == OP_WRITE) begin
      weight_tab[w.bin_index] = w.green_weight;
      gain_tab[w.bin_index]   = w.loudness_gain;
      bin_loaded[w.bin_index] = 1'b1;
      return;
    end
    wt  = 64'((weight_tab[w.bin_index] > W_ONE) ? W_ONE : weight_tab[w.bin_index]);
    amp = (64'(w.bin_amplitude) * gain_tab[w.bin_index]) >> 12;
    pw  = amp * amp;
    gsh = (pw * wt) >> 16;
    green_sum = sat_sum(green_sum, gsh);
    if (w.bin_index < pivot_q) red_sum = sat_sum(red_sum, pw - gsh);
    else blue_sum = sat_sum(blue_sum, pw - gsh);
    if (!w.last_of_frame) return;
    mr = (root_floor(red_sum) * red_scale_q) >> 12;
    mg = root_floor(green_sum);
    mb = (root_floor(blue_sum) * blue_scale_q) >> 12;
    red_sum = '0;
    green_sum = '0;
    blue_sum = '0;
    if (w.frame_time_us != 0) begin
      up = step_size(64'(rise_base_q), 64'(w.frame_time_us));
      dn = step_size(64'(fall_base_q), 64'(w.frame_time_us));
      settle_level(0, (mr * overall_q) >> 4, up, dn);
      settle_level(1, (mg * overall_q) >> 4, up, dn);
      settle_level(2, (mb * overall_q) >> 4, up, dn);
    end
    r.red_level   = level_q12[0][23:12];
    r.green_level = level_q12[1][23:12];
    r.blue_level  = level_q12[2][23:12];
    expected_levels.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Sends one word after a drawn number of idle cycles, or at once when tx_no_gaps is set.
  task automatic send_word(srls_in_t w);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_levels(w);
  endtask

  task automatic write_bin(bit [7:0] idx, bit [16:0] wt, bit [15:0] gain);
    srls_in_t w;
    w = srls_in_t'({$urandom, $urandom, $urandom});
    w.operation     = OP_WRITE;
    w.bin_index     = idx;
    w.green_weight  = wt;
    w.loudness_gain = gain;
    send_word(w);
  endtask

  task automatic sample_bin(bit [7:0] idx, bit [15:0] amp, bit last, bit [19:0] dt);
    srls_in_t w;
    w = srls_in_t'({$urandom, $urandom, $urandom});
    w.operation     = OP_SAMPLE;
    w.bin_index     = idx;
    w.bin_amplitude = amp;
    w.last_of_frame = last;
    w.frame_time_us = dt;
    send_word(w);
  endtask

  function automatic bit [7:0] pick_loaded_bin();
    bit [7:0] idx;
    do idx = 8'($urandom_range(0, 255)); while (!bin_loaded[idx]);
    return idx;
  endfunction

  // Waits until the block has delivered everything and gone quiet.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RED_SCALE:  red_scale_q = value[15:0];
      REG_BLUE_SCALE: blue_scale_q = value[15:0];
      REG_OVERALL:    overall_q = value[15:0];
      REG_LIMIT:      limit_q = value[11:0];
      REG_PIVOT:      pivot_q = value[8:0];
      REG_RISE:       rise_base_q = value[23:0];
      REG_FALL:       fall_base_q = value[23:0];
      default: ;
    endcase
  endtask

  task automatic load_config(bit [15:0] rs, bit [15:0] bs, bit [15:0] os,
                             bit [11:0] lim, bit [8:0] piv, bit [23:0] rb,
                             bit [23:0] fb);
    wait_idle();
    write_reg(REG_RED_SCALE, 32'(rs));
    write_reg(REG_BLUE_SCALE, 32'(bs));
    write_reg(REG_OVERALL, 32'(os));
    write_reg(REG_LIMIT, 32'(lim));
    write_reg(REG_PIVOT, 32'(piv));
    write_reg(REG_RISE, 32'(rb));
    write_reg(REG_FALL, 32'(fb));
  endtask

  function automatic bit [19:0] draw_frame_time();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'($urandom_range(1, 20));
      3: return 20'($urandom);
      default: return 20'($urandom_range(8000, 60000));
    endcase
  endfunction

  task automatic random_frame(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        write_bin(8'($urandom), 17'($urandom_range(0, 131071)), 16'($urandom));
      sample_bin(pick_loaded_bin(), 16'($urandom >> $urandom_range(0, 16)),
                 k == n - 1, draw_frame_time());
    end
  endtask

  task automatic test_directed();
    write_bin(8'd0, 17'd0, 16'hFFFF);
    write_bin(8'd255, W_ONE, 16'd4096);
    write_bin(8'd63, 17'h1FFFF, 16'd8192);
    write_bin(8'd64, 17'd32768, 16'd0);
    write_bin(8'd100, 17'd12345, 16'd5000);
    sample_bin(8'd0, 16'hFFFF, 1'b0, 20'd0);
    sample_bin(8'd63, 16'd40000, 1'b0, 20'd0);
    sample_bin(8'd255, 16'hFFFF, 1'b1, 20'd16000);
    sample_bin(8'd64, 16'hFFFF, 1'b1, 20'hFFFFF);
    sample_bin(8'd100, 16'd0, 1'b1, 20'd1);
    sample_bin(8'd0, 16'd30000, 1'b1, 20'd0);
    // A table write, whose last flag is random, must not end the frame.
    write_bin(8'd7, 17'd1000, 16'd4096);
    sample_bin(8'd7, 16'd5000, 1'b1, 20'd20000);
    sample_bin(8'd255, 16'd0, 1'b1, 20'd30000);
    sample_bin(8'd0, 16'd0, 1'b1, 20'd50000);
  endtask

  task automatic test_saturation();
    for (int k = 0; k < 260; k++)
      sample_bin(8'd0, 16'hFFFF, k == 259, 20'd25000);
  endtask

  task automatic test_config_extremes();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095, 9'd256, 24'd0, 24'hFFFFFF);
    repeat (6) random_frame($urandom_range(1, 6));
    load_config(16'd0, 16'd0, 16'd0, 12'd0, 9'd0, 24'hFFFFFF, 24'd0);
    repeat (6) random_frame($urandom_range(1, 6));
    load_config(16'd4096, 16'd4096, 16'd1, 12'd2000, 9'd128, 24'd100000, 24'd300000);
    repeat (6) random_frame($urandom_range(1, 6));
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      load_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 20000)),
                  12'($urandom), 9'($urandom_range(0, 256)),
                  24'($urandom_range(0, 1000000)), 24'($urandom_range(0, 2000000)));
      for (int i = 0; i < 32; i++)
        write_bin(8'($urandom), 17'($urandom_range(0, 131071)), 16'($urandom));
      for (int f = 0; f < 24; f++) begin
        tx_no_gaps = ($urandom_range(0, 4) == 0);
        random_frame($urandom_range(1, 14));
      end
      tx_no_gaps = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    rx_long_hold = 1'b1;
    tx_no_gaps   = 1'b1;
    repeat (6) random_frame($urandom_range(1, 3));
    tx_no_gaps   = 1'b0;
  endtask

  // Result side: random stalls, one long hold on request, field checks.
  initial begin
    srls_out_t got;
    srls_out_t want;
    int        stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      got = out_data_o;
      @(posedge clk_i);
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected word, green_level", int'(got.green_level), 0);
      end else begin
        want = expected_levels.pop_front();
        if (got.red_level != want.red_level)
          report_mismatch("red_level", int'(got.red_level), int'(want.red_level));
        if (got.green_level != want.green_level)
          report_mismatch("green_level", int'(got.green_level), int'(want.green_level));
        if (got.blue_level != want.blue_level)
          report_mismatch("blue_level", int'(got.blue_level), int'(want.blue_level));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_cycles = 0;
    mismatch_count = 0;
    rx_long_hold = 1'b0;
    tx_no_gaps  = 1'b0;
    red_scale_q = 16'd9860;
    blue_scale_q = 16'd6592;
    overall_q   = 16'd12000;
    limit_q     = 12'd4095;
    pivot_q     = 9'd64;
    rise_base_q = 24'd166950;
    fall_base_q = 24'd500850;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_config_extremes();
    test_random();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
